// File: rtl/gnfs_rcb_pkg.sv
// shared types, codes and defaults for the relation column builder
// no dependencies
package gnfs_rcb_pkg;

    localparam int CHAR_DEPTH_DEFAULT = 32;
    localparam int BASE_LIMIT_DEFAULT = 1048576;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_START  = 2'd1;
    localparam logic [1:0] KIND_FACTOR = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    localparam logic [1:0] CFG_NOT_MONIC = 2'd0;
    localparam logic [1:0] CFG_RAT_SIZE  = 2'd1;
    localparam logic [1:0] CFG_ALG_SIZE  = 2'd2;
    localparam logic [1:0] CFG_CHAR_CNT  = 2'd3;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_START,
        OP_FACTOR,
        OP_END
    } op_t;

    typedef struct packed {
        logic        not_monic;
        logic [20:0] rat_size;
        logic [20:0] alg_size;
        logic [5:0]  char_count;
    } cfg_t;

    typedef struct packed {
        op_t         op;
        logic [4:0]  slot;
        logic [31:0] q;
        logic [31:0] s;
        logic        neg_sign;
        logic [47:0] a;
        logic [31:0] b;
        logic [31:0] p;
        logic [21:0] row;
        logic        emit;
    } cmd_t;

    typedef struct packed {
        logic        start;
        logic [6:0]  steps;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] rem;
    } mod_rsp_t;

endpackage

// File: rtl/gnfs_rcb_ram.sv
// generic single write port ram with registered read
// no dependencies
module gnfs_rcb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/gnfs_rcb_fifo.sv
// small command queue between front and back
// depends on gnfs_rcb_pkg
module gnfs_rcb_fifo #(
    parameter int DEPTH = gnfs_rcb_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  gnfs_rcb_pkg::cmd_t push_data,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output gnfs_rcb_pkg::cmd_t head
);

    localparam int QW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    gnfs_rcb_pkg::cmd_t mem_reg [DEPTH];
    logic [QW-1:0] wptr_reg, rptr_reg;
    logic [CW-1:0] count_reg;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                mem_reg[wptr_reg] <= push_data;
                wptr_reg <= (wptr_reg == QW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == QW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            count_reg <= count_reg + CW'(push) - CW'(pop);
        end
    end

endmodule

// File: rtl/gnfs_rcb_front.sv
// input side: takes beats, classifies them and works out factor rows
// depends on gnfs_rcb_pkg
module gnfs_rcb_front (
    input  gnfs_rcb_pkg::cfg_t cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         kind,
    input  logic [4:0]         entry_slot,
    input  logic [31:0]        char_prime,
    input  logic [31:0]        char_root,
    input  logic               negative_sign,
    input  logic signed [47:0] pair_a,
    input  logic [31:0]        pair_b,
    input  logic [31:0]        free_prime,
    input  logic               algebraic_side,
    input  logic [19:0]        base_position,
    input  logic               exponent_odd,
    input  logic               fifo_full,
    output logic               push,
    output gnfs_rcb_pkg::cmd_t push_data
);

    logic [21:0] off;
    logic        in_rat, in_alg;

    assign in_ready = !fifo_full;
    assign push     = in_valid && !fifo_full;
    assign off      = 22'(cfg.not_monic);
    assign in_rat   = {1'b0, base_position} < cfg.rat_size;
    assign in_alg   = {1'b0, base_position} < cfg.alg_size;

    always_comb
    begin
        push_data          = '0;
        push_data.slot     = entry_slot;
        push_data.q        = char_prime;
        push_data.s        = char_root;
        push_data.neg_sign = negative_sign;
        push_data.a        = pair_a;
        push_data.b        = pair_b;
        push_data.p        = free_prime;
        case (kind)
            gnfs_rcb_pkg::KIND_LOAD:   push_data.op = gnfs_rcb_pkg::OP_LOAD;
            gnfs_rcb_pkg::KIND_START:  push_data.op = gnfs_rcb_pkg::OP_START;
            gnfs_rcb_pkg::KIND_FACTOR: push_data.op = gnfs_rcb_pkg::OP_FACTOR;
            gnfs_rcb_pkg::KIND_END:    push_data.op = gnfs_rcb_pkg::OP_END;
            default:                   push_data.op = gnfs_rcb_pkg::OP_END;
        endcase
        if (algebraic_side)
        begin
            push_data.row  = 22'd1 + off + 22'(cfg.rat_size) + 22'(base_position);
            push_data.emit = exponent_odd && in_alg;
        end
        else
        begin
            push_data.row  = 22'd1 + off + 22'(base_position);
            push_data.emit = exponent_odd && in_rat;
        end
    end

endmodule

// File: rtl/gnfs_rcb_mod.sv
// bit-serial remainder unit, one dividend bit per cycle
// depends on gnfs_rcb_pkg
module gnfs_rcb_mod (
    input  logic                   clk,
    input  logic                   rst_n,
    input  gnfs_rcb_pkg::mod_req_t req,
    output gnfs_rcb_pkg::mod_rsp_t rsp
);

    logic [31:0] rem_reg, div_q_reg;
    logic [63:0] dvd_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [32:0] trial, t_next;

    assign trial  = {rem_reg, dvd_reg[63]};
    assign t_next = (trial >= {1'b0, div_q_reg}) ? trial - {1'b0, div_q_reg} : trial;
    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            rem_reg   <= '0;
            dvd_reg   <= '0;
            div_q_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                rem_reg   <= '0;
                dvd_reg   <= req.dividend;
                div_q_reg <= req.divisor;
                cnt_reg   <= req.steps;
            end
            else if (busy_reg)
            begin
                rem_reg <= t_next[31:0];
                dvd_reg <= {dvd_reg[62:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// File: rtl/gnfs_rcb_back.sv
// execution side: table writes, row output and the character loop
// depends on gnfs_rcb_pkg, drives gnfs_rcb_mod and the character ram
module gnfs_rcb_back #(
    parameter int CHAR_DEPTH = gnfs_rcb_pkg::CHAR_DEPTH_DEFAULT,
    localparam int AW = (CHAR_DEPTH > 1) ? $clog2(CHAR_DEPTH) : 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  gnfs_rcb_pkg::cfg_t     cfg,
    input  logic                   head_valid,
    input  gnfs_rcb_pkg::cmd_t     head,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [21:0]            row_index,
    output logic                   last_row,
    output logic                   ram_we,
    output logic [AW-1:0]          ram_waddr,
    output logic [63:0]            ram_wdata,
    output logic [AW-1:0]          ram_raddr,
    input  logic [63:0]            ram_rdata,
    output gnfs_rcb_pkg::mod_req_t mod_req,
    input  gnfs_rcb_pkg::mod_rsp_t mod_rsp
);

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_SIGN, S_RD, S_CHK, S_MF, S_M1, S_M2, S_M3,
        S_MUL, S_M4, S_JAC, S_NEXT, S_FLUSH
    } state_t;

    state_t             state_reg;
    gnfs_rcb_pkg::cmd_t cmd_reg;
    gnfs_rcb_pkg::mod_req_t mreq_reg;
    logic [47:0] held_a_reg;
    logic [31:0] held_b_reg, held_p_reg;
    logic        outv_reg, last_reg;
    logic [21:0] row_reg, pend_reg;
    logic        pend_valid_reg, hit_reg;
    logic [5:0]  i_reg;
    logic [31:0] q_reg, s_reg, am_reg, r2_reg;
    logic [63:0] prod_reg;
    logic [31:0] jn_reg, jq_reg;
    logic        jneg_reg;

    logic        can_emit, slot_ok, neg;
    logic [47:0] mag;
    logic [21:0] off, base;
    logic [31:0] num;
    logic [32:0] num_wide;

    assign can_emit  = !outv_reg || out_ready;
    assign pop       = (state_reg == S_IDLE) && head_valid;
    assign out_valid = outv_reg;
    assign row_index = row_reg;
    assign last_row  = last_reg;
    assign slot_ok   = {27'd0, cmd_reg.slot} < 32'(CHAR_DEPTH);
    assign ram_we    = (state_reg == S_EXEC) && (cmd_reg.op == gnfs_rcb_pkg::OP_LOAD) && slot_ok;
    assign ram_waddr = AW'(cmd_reg.slot);
    assign ram_wdata = {cmd_reg.q, cmd_reg.s};
    assign ram_raddr = i_reg[AW-1:0];
    assign mod_req   = mreq_reg;
    assign neg       = held_a_reg[47];
    assign mag       = neg ? (~held_a_reg + 48'd1) : held_a_reg;
    assign off       = 22'(cfg.not_monic);
    assign base      = 22'd1 + off + 22'(cfg.rat_size) + 22'(cfg.alg_size);
    assign num_wide  = (am_reg >= mod_rsp.rem) ? {1'b0, am_reg - mod_rsp.rem}
                     : {1'b0, am_reg} + {1'b0, q_reg} - {1'b0, mod_rsp.rem};
    assign num       = num_wide[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= '0;
            mreq_reg       <= '0;
            held_a_reg     <= '0;
            held_b_reg     <= '0;
            held_p_reg     <= '0;
            outv_reg       <= 1'b0;
            last_reg       <= 1'b0;
            row_reg        <= '0;
            pend_reg       <= '0;
            pend_valid_reg <= 1'b0;
            hit_reg        <= 1'b0;
            i_reg          <= '0;
            q_reg          <= '0;
            s_reg          <= '0;
            am_reg         <= '0;
            r2_reg         <= '0;
            prod_reg       <= '0;
            jn_reg         <= '0;
            jq_reg         <= '0;
            jneg_reg       <= 1'b0;
        end
        else
        begin
            mreq_reg.start <= 1'b0;
            if (outv_reg && out_ready)
            begin
                outv_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (head_valid)
                    begin
                        cmd_reg   <= head;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    case (cmd_reg.op)
                        gnfs_rcb_pkg::OP_START:
                        begin
                            held_a_reg <= cmd_reg.a;
                            held_b_reg <= cmd_reg.b;
                            held_p_reg <= cmd_reg.p;
                            if (cfg.not_monic || cmd_reg.neg_sign)
                            begin
                                if (can_emit)
                                begin
                                    outv_reg  <= 1'b1;
                                    row_reg   <= cfg.not_monic ? 22'd0 : off;
                                    last_reg  <= !(cfg.not_monic && cmd_reg.neg_sign);
                                    state_reg <= (cfg.not_monic && cmd_reg.neg_sign) ? S_SIGN
                                                                                     : S_IDLE;
                                end
                            end
                            else
                            begin
                                state_reg <= S_IDLE;
                            end
                        end
                        gnfs_rcb_pkg::OP_FACTOR:
                        begin
                            if (!cmd_reg.emit)
                            begin
                                state_reg <= S_IDLE;
                            end
                            else if (can_emit)
                            begin
                                outv_reg  <= 1'b1;
                                row_reg   <= cmd_reg.row;
                                last_reg  <= 1'b1;
                                state_reg <= S_IDLE;
                            end
                        end
                        gnfs_rcb_pkg::OP_END:
                        begin
                            i_reg          <= '0;
                            pend_valid_reg <= 1'b0;
                            hit_reg        <= 1'b0;
                            state_reg      <= (cfg.char_count == '0) ? S_IDLE : S_RD;
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_SIGN:
                begin
                    if (can_emit)
                    begin
                        outv_reg  <= 1'b1;
                        row_reg   <= off;
                        last_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    q_reg <= ram_rdata[63:32];
                    s_reg <= ram_rdata[31:0];
                    mreq_reg.divisor <= ram_rdata[63:32];
                    if (!ram_rdata[32])
                    begin
                        state_reg <= S_NEXT;
                    end
                    else if (held_b_reg == '0)
                    begin
                        mreq_reg.start    <= 1'b1;
                        mreq_reg.dividend <= {held_p_reg, 32'd0};
                        mreq_reg.steps    <= 7'd32;
                        state_reg         <= S_MF;
                    end
                    else
                    begin
                        mreq_reg.start    <= 1'b1;
                        mreq_reg.dividend <= {mag, 16'd0};
                        mreq_reg.steps    <= 7'd48;
                        state_reg         <= S_M1;
                    end
                end
                S_MF:
                begin
                    if (mod_rsp.done)
                    begin
                        jn_reg    <= mod_rsp.rem;
                        jq_reg    <= q_reg;
                        jneg_reg  <= 1'b0;
                        state_reg <= S_JAC;
                    end
                end
                S_M1:
                begin
                    if (mod_rsp.done)
                    begin
                        am_reg <= (neg && mod_rsp.rem != '0) ? q_reg - mod_rsp.rem : mod_rsp.rem;
                        mreq_reg.start    <= 1'b1;
                        mreq_reg.dividend <= {held_b_reg, 32'd0};
                        mreq_reg.steps    <= 7'd32;
                        state_reg         <= S_M2;
                    end
                end
                S_M2:
                begin
                    if (mod_rsp.done)
                    begin
                        r2_reg            <= mod_rsp.rem;
                        mreq_reg.start    <= 1'b1;
                        mreq_reg.dividend <= {s_reg, 32'd0};
                        mreq_reg.steps    <= 7'd32;
                        state_reg         <= S_M3;
                    end
                end
                S_M3:
                begin
                    if (mod_rsp.done)
                    begin
                        prod_reg  <= r2_reg * mod_rsp.rem;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    mreq_reg.start    <= 1'b1;
                    mreq_reg.dividend <= prod_reg;
                    mreq_reg.steps    <= 7'd64;
                    state_reg         <= S_M4;
                end
                S_M4:
                begin
                    if (mod_rsp.done)
                    begin
                        jn_reg    <= num;
                        jq_reg    <= q_reg;
                        jneg_reg  <= 1'b0;
                        state_reg <= S_JAC;
                    end
                end
                S_JAC:
                begin
                    if (jn_reg == '0)
                    begin
                        hit_reg   <= (jq_reg == 32'd1) && jneg_reg;
                        state_reg <= S_NEXT;
                    end
                    else if (!jn_reg[0])
                    begin
                        jn_reg <= {1'b0, jn_reg[31:1]};
                        if (jq_reg[2:0] == 3'd3 || jq_reg[2:0] == 3'd5)
                        begin
                            jneg_reg <= !jneg_reg;
                        end
                    end
                    else if (jn_reg < jq_reg)
                    begin
                        jn_reg <= jq_reg - jn_reg;
                        jq_reg <= jn_reg;
                        if (jn_reg[1:0] == 2'd3 && jq_reg[1:0] == 2'd3)
                        begin
                            jneg_reg <= !jneg_reg;
                        end
                    end
                    else
                    begin
                        jn_reg <= jn_reg - jq_reg;
                    end
                end
                S_NEXT:
                begin
                    if (!hit_reg || !pend_valid_reg || can_emit)
                    begin
                        if (hit_reg)
                        begin
                            if (pend_valid_reg)
                            begin
                                outv_reg <= 1'b1;
                                row_reg  <= pend_reg;
                                last_reg <= 1'b0;
                            end
                            pend_reg       <= base + 22'(i_reg);
                            pend_valid_reg <= 1'b1;
                        end
                        hit_reg   <= 1'b0;
                        i_reg     <= i_reg + 6'd1;
                        state_reg <= (i_reg + 6'd1 == cfg.char_count) ? S_FLUSH : S_RD;
                    end
                end
                S_FLUSH:
                begin
                    if (!pend_valid_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (can_emit)
                    begin
                        outv_reg       <= 1'b1;
                        row_reg        <= pend_reg;
                        last_reg       <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !pend_valid_reg)
        else $error("pending character row left behind");

    a_jacobi_odd_modulus: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_JAC |-> jq_reg[0])
        else $error("jacobi modulus became even");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD || state_reg == S_CHK) |-> i_reg < cfg.char_count)
        else $error("character index past count");

    a_mod_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        mod_rsp.done |-> (state_reg == S_MF || state_reg == S_M1 || state_reg == S_M2
                          || state_reg == S_M3 || state_reg == S_M4))
        else $error("remainder finished outside a wait state");

endmodule

// File: rtl/gnfs_relation_column_builder_unit.sv
// path: a start or factor row passes through the queue, the command register and the output register
// the queue takes new beats while the back side works through one command at a time
// a relation end reads each character in turn from the table and runs serial
// remainders (48+32+32+64 bits), a single 32-bit one on a free relation, none on an even modulus,
// then the jacobi steps; output stalls add to all of these
// reset: all control state and held relation values cleared, no clearing pass
module gnfs_relation_column_builder_unit #(
    parameter int CHAR_DEPTH = gnfs_rcb_pkg::CHAR_DEPTH_DEFAULT,
    parameter int BASE_LIMIT = gnfs_rcb_pkg::BASE_LIMIT_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [20:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         kind,
    input  logic [4:0]         entry_slot,
    input  logic [31:0]        char_prime,
    input  logic [31:0]        char_root,
    input  logic               negative_sign,
    input  logic signed [47:0] pair_a,
    input  logic [31:0]        pair_b,
    input  logic [31:0]        free_prime,
    input  logic               algebraic_side,
    input  logic [19:0]        base_position,
    input  logic               exponent_odd,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [21:0]        row_index,
    output logic               last_row
);

    localparam int AW = (CHAR_DEPTH > 1) ? $clog2(CHAR_DEPTH) : 1;

    gnfs_rcb_pkg::cfg_t     cfg_reg;
    gnfs_rcb_pkg::cmd_t     push_data, head;
    gnfs_rcb_pkg::mod_req_t mod_req;
    gnfs_rcb_pkg::mod_rsp_t mod_rsp;
    logic          push, fifo_full, pop, head_valid, ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [63:0]   ram_wdata, ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                gnfs_rcb_pkg::CFG_NOT_MONIC: cfg_reg.not_monic <= cfg_data[0];
                gnfs_rcb_pkg::CFG_RAT_SIZE:
                    cfg_reg.rat_size <= ({11'd0, cfg_data} > 32'(BASE_LIMIT))
                                        ? 21'(BASE_LIMIT) : cfg_data;
                gnfs_rcb_pkg::CFG_ALG_SIZE:
                    cfg_reg.alg_size <= ({11'd0, cfg_data} > 32'(BASE_LIMIT))
                                        ? 21'(BASE_LIMIT) : cfg_data;
                gnfs_rcb_pkg::CFG_CHAR_CNT:
                    cfg_reg.char_count <= ({26'd0, cfg_data[5:0]} > 32'(CHAR_DEPTH))
                                          ? 6'(CHAR_DEPTH) : cfg_data[5:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    gnfs_rcb_front u_front (
        .cfg            (cfg_reg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .entry_slot     (entry_slot),
        .char_prime     (char_prime),
        .char_root      (char_root),
        .negative_sign  (negative_sign),
        .pair_a         (pair_a),
        .pair_b         (pair_b),
        .free_prime     (free_prime),
        .algebraic_side (algebraic_side),
        .base_position  (base_position),
        .exponent_odd   (exponent_odd),
        .fifo_full      (fifo_full),
        .push           (push),
        .push_data      (push_data)
    );

    gnfs_rcb_fifo #(
        .DEPTH (gnfs_rcb_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    gnfs_rcb_ram #(
        .WIDTH (64),
        .DEPTH (CHAR_DEPTH)
    ) u_char_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gnfs_rcb_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    gnfs_rcb_back #(
        .CHAR_DEPTH (CHAR_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .row_index  (row_index),
        .last_row   (last_row),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .mod_req    (mod_req),
        .mod_rsp    (mod_rsp)
    );

endmodule

// File: bench/gnfs_relation_column_builder_unit_test.sv
// self-checking bench for the relation column builder, random relations vs a row predictor
// depends on gnfs_rcb_pkg and gnfs_relation_column_builder_unit
module gnfs_relation_column_builder_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  slot;
        logic [31:0] q;
        logic [31:0] s;
        logic        neg;
        logic [47:0] a;
        logic [31:0] b;
        logic [31:0] p;
        logic        alg;
        logic [19:0] pos;
        logic        odd;
    } beat_t;

    typedef struct packed {
        logic [21:0] row;
        logic        last;
    } row_t;

    localparam int WATCHDOG = 200000;
    localparam int SETTLE   = 40000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [1:0] cfg_index = gnfs_rcb_pkg::CFG_NOT_MONIC;
    logic [20:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    beat_t cur = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [21:0] row_index;
    logic last_row;

    beat_t pending[$];
    row_t rows_due[$];
    int errors = 0;
    int idle_cycles = 0;
    int in_gap = 0;
    int out_gap = 0;
    bit in_took = 1'b0;

    logic [31:0] tq[32];
    logic [31:0] ts[32];
    logic [47:0] h_a;
    logic [31:0] h_b;
    logic [31:0] h_p;
    logic        m_nm;
    logic [20:0] m_rat;
    logic [20:0] m_alg;
    logic [5:0]  m_cc;

    gnfs_relation_column_builder_unit i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .kind(cur.kind), .entry_slot(cur.slot), .char_prime(cur.q), .char_root(cur.s),
        .negative_sign(cur.neg), .pair_a(cur.a), .pair_b(cur.b), .free_prime(cur.p),
        .algebraic_side(cur.alg), .base_position(cur.pos), .exponent_odd(cur.odd),
        .out_valid(out_valid), .out_ready(out_ready), .row_index(row_index),
        .last_row(last_row)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int jacobi(longint unsigned n, longint unsigned q);
        int res;
        longint unsigned t;
        res = 1;
        while (n != 0)
        begin
            while ((n & 1) == 0)
            begin
                n = n >> 1;
                if ((q & 7) == 3 || (q & 7) == 5)
                    res = -res;
            end
            t = n;
            n = q;
            q = t;
            if ((n & 3) == 3 && (q & 3) == 3)
                res = -res;
            n = n % q;
        end
        return (q == 1) ? res : 0;
    endfunction

    task automatic push_row(input longint unsigned r);
        row_t e;
        e.row = r[21:0];
        e.last = 1'b0;
        rows_due.push_back(e);
    endtask

    task automatic predict_rows(input beat_t it);
        int rows_prior;
        longint unsigned off, base, mag, q, num, am, bs;
        row_t e;
        rows_prior = rows_due.size();
        off = {63'd0, m_nm};
        case (it.kind)
            gnfs_rcb_pkg::KIND_LOAD:
            begin
                tq[it.slot] = it.q;
                ts[it.slot] = it.s;
            end
            gnfs_rcb_pkg::KIND_START:
            begin
                h_a = it.a;
                h_b = it.b;
                h_p = it.p;
                if (m_nm)
                    push_row(0);
                if (it.neg)
                    push_row(off);
            end
            gnfs_rcb_pkg::KIND_FACTOR:
            begin
                if (it.odd && !it.alg && it.pos < m_rat)
                    push_row(1 + off + it.pos);
                if (it.odd && it.alg && it.pos < m_alg)
                    push_row(1 + off + m_rat + it.pos);
            end
            gnfs_rcb_pkg::KIND_END:
            begin
                base = 1 + off + m_rat + m_alg;
                mag = {16'd0, h_a[47] ? (~h_a + 48'd1) : h_a};
                for (int i = 0; i < m_cc; i++)
                begin
                    q = {32'd0, tq[i]};
                    if (q[0])
                    begin
                        if (h_b == 0)
                            num = h_p % q;
                        else
                        begin
                            am = mag % q;
                            bs = ((h_b % q) * (ts[i] % q)) % q;
                            if (h_a[47])
                                am = (q - am) % q;
                            num = (am + q - bs) % q;
                        end
                        if (jacobi(num, q) == -1)
                            push_row(base + i);
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (rows_due.size() > rows_prior)
        begin
            e = rows_due.pop_back();
            e.last = 1'b1;
            rows_due.push_back(e);
        end
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_took)
                in_gap = pick_gap();
            if (!in_valid || in_took)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending.size() > 0)
                begin
                    cur <= pending.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            if (out_gap > 0)
            begin
                out_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                out_gap = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        row_t e;
        in_took = 1'b0;
        if (rst_n)
        begin
            idle_cycles = idle_cycles + 1;
            if (in_valid && in_ready)
            begin
                in_took = 1'b1;
                predict_rows(cur);
                idle_cycles = 0;
            end
            if (out_valid && out_ready)
            begin
                idle_cycles = 0;
                if (rows_due.size() == 0)
                begin
                    $error("unexpected row beat %0d", row_index);
                    errors++;
                end
                else
                begin
                    e = rows_due.pop_front();
                    if (row_index !== e.row)
                    begin
                        $error("row_index expected %0d actual %0d", e.row, row_index);
                        errors++;
                    end
                    if (last_row !== e.last)
                    begin
                        $error("last_row expected %0d actual %0d", e.last, last_row);
                        errors++;
                    end
                end
            end
            if (idle_cycles > WATCHDOG)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [20:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            gnfs_rcb_pkg::CFG_NOT_MONIC: m_nm = val[0];
            gnfs_rcb_pkg::CFG_RAT_SIZE: m_rat = (val > 21'd1048576) ? 21'd1048576 : val;
            gnfs_rcb_pkg::CFG_ALG_SIZE: m_alg = (val > 21'd1048576) ? 21'd1048576 : val;
            gnfs_rcb_pkg::CFG_CHAR_CNT: m_cc = (val[5:0] > 6'd32) ? 6'd32 : val[5:0];
            default: m_nm = m_nm;
        endcase
    endtask

    // in-flight beats with no rows left can still take a few relation ends
    task automatic drain();
        while (pending.size() > 0 || in_valid || rows_due.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_odd_q();
        case ($urandom_range(0, 5))
            0: return 32'd3;
            1: return 32'hFFFFFFFF;
            2: return $urandom_range(3, 200) | 32'd1;
            3: return $urandom & 32'hFFFFFFFE;
            4: return 32'd1;
            default: return $urandom | 32'd1;
        endcase
    endfunction

    function automatic beat_t rand_beat(input logic [1:0] k);
        beat_t it;
        it = '0;
        it.kind = k;
        it.slot = 5'($urandom);
        it.q = rand_odd_q();
        it.s = $urandom;
        it.neg = 1'($urandom);
        it.a = 48'({$urandom, $urandom});
        if ($urandom_range(0, 2) == 0)
            it.a = 48'(int'($urandom_range(0, 2000)) - 1000);
        it.b = ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom;
        it.p = $urandom;
        it.alg = 1'($urandom);
        it.pos = 20'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 40) : $urandom);
        it.odd = $urandom_range(0, 3) != 0;
        return it;
    endfunction

    task automatic load_table();
        beat_t it;
        for (int i = 0; i < 32; i++)
        begin
            it = rand_beat(gnfs_rcb_pkg::KIND_LOAD);
            it.slot = 5'(i);
            pending.push_back(it);
        end
    endtask

    task automatic relation();
        int nf;
        pending.push_back(rand_beat(gnfs_rcb_pkg::KIND_START));
        nf = $urandom_range(0, 6);
        for (int i = 0; i < nf; i++)
            pending.push_back(rand_beat(gnfs_rcb_pkg::KIND_FACTOR));
        pending.push_back(rand_beat(gnfs_rcb_pkg::KIND_END));
    endtask

    initial
    begin
        beat_t it;
        int count;
        m_nm = 0; m_rat = 0; m_alg = 0; m_cc = 0;
        h_a = 0; h_b = 0; h_p = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: end without start, field extremes, table load
        pending.push_back(rand_beat(gnfs_rcb_pkg::KIND_END));
        drain();
        write_reg(gnfs_rcb_pkg::CFG_NOT_MONIC, 21'd1);
        write_reg(gnfs_rcb_pkg::CFG_RAT_SIZE, 21'd1048576);
        write_reg(gnfs_rcb_pkg::CFG_ALG_SIZE, 21'h1FFFFF);
        write_reg(gnfs_rcb_pkg::CFG_CHAR_CNT, 21'd63);
        it = rand_beat(gnfs_rcb_pkg::KIND_FACTOR);
        it.pos = 20'hFFFFF; it.alg = 1; it.odd = 1;
        pending.push_back(it);
        it.alg = 0;
        pending.push_back(it);
        it.odd = 0;
        pending.push_back(it);
        load_table();
        it = rand_beat(gnfs_rcb_pkg::KIND_START);
        it.a = 48'h800000000000; it.b = 32'hFFFFFFFF; it.neg = 1;
        pending.push_back(it);
        pending.push_back(rand_beat(gnfs_rcb_pkg::KIND_END));
        it.a = 48'h7FFFFFFFFFFF; it.b = 0; it.p = 32'hFFFFFFFF; it.neg = 0;
        pending.push_back(it);
        pending.push_back(rand_beat(gnfs_rcb_pkg::KIND_END));
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(gnfs_rcb_pkg::CFG_NOT_MONIC, 21'($urandom_range(0, 1)));
            write_reg(gnfs_rcb_pkg::CFG_RAT_SIZE,
                      (ph == 0) ? 21'd0 : 21'($urandom_range(0, 30)));
            write_reg(gnfs_rcb_pkg::CFG_ALG_SIZE,
                      (ph == 1) ? 21'd0 : 21'($urandom_range(0, 30)));
            write_reg(gnfs_rcb_pkg::CFG_CHAR_CNT,
                      (ph == 2) ? 21'd0 : 21'($urandom_range(1, 12)));
            if ($urandom_range(0, 1))
                load_table();
            count = pending.size() + 55;
            while (pending.size() < count)
            begin
                if ($urandom_range(0, 9) == 0)
                    pending.push_back(rand_beat(2'($urandom)));
                else
                    relation();
            end
            drain();
        end

        if (errors == 0 && rows_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
